// ===== hw/rtl/esd_pkg.sv =====
// Shared types, codes and constants of the escape sequence decoder.
package esd_pkg;

  // Default width of the internal newline counter.
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // One input byte causes at most three result words.
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned RCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int unsigned RIDX_W      = $clog2(MAX_RESULTS);

  // Result queue between the decode stage and the output channel.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Reported line count width.
  localparam int unsigned LINE_W = 32;

  // Characters with a special meaning in the escaped text.
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
  localparam logic [7:0] CHAR_HEX_INTRO = 8'h78;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_SEVEN     = 8'h37;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F   = 8'h66;

  // Parser mode.
  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_HEX_FIRST,
    MODE_HEX,
    MODE_OCT
  } mode_e;

  // Final status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRAIL     = 3'd1,
    ST_BAD_HEX   = 3'd2,
    ST_HEX_RANGE = 3'd3,
    ST_OCT_RANGE = 3'd4
  } status_e;

  // Parser state apart from the newline counter.
  typedef struct packed {
    mode_e      mode;
    logic [7:0] digit;
    logic       ovf;
    status_e    err;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    mode:  MODE_NORMAL,
    digit: 8'd0,
    ovf:   1'b0,
    err:   ST_OK
  };

  // One result word.
  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              end_of_run;
    logic              done_res;
    logic [2:0]        status;
    logic [LINE_W-1:0] line_count;
  } result_t;

endpackage

// ===== hw/rtl/esd_in_if.sv =====
// Input channel of the escape sequence decoder: one raw text byte per word.
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source (output valid, output in_byte, output last, input ready);
  modport sink (input valid, input in_byte, input last, output ready);
endinterface

// ===== hw/rtl/esd_out_if.sv =====
// Output channel of the escape sequence decoder: one decoded byte or final status per word.
interface esd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        end_of_run;
  logic        done_res;
  logic [2:0]  status;
  logic [31:0] line_count;

  modport source (
    output valid, output out_byte, output byte_valid, output end_of_run,
    output done_res, output status, output line_count, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_valid, input end_of_run,
    input done_res, input status, input line_count, output ready
  );
endinterface

// ===== hw/rtl/esd_step.sv =====
// Decode logic for one text byte: next parser state and up to three result words.
module esd_step #(
  parameter int unsigned COUNT_WIDTH = esd_pkg::COUNT_WIDTH_DEF
) (
  input  esd_pkg::parse_state_t                            state_i,
  input  logic [COUNT_WIDTH-1:0]                           lines_i,
  input  logic [7:0]                                       byte_i,
  input  logic                                             last_i,
  output esd_pkg::parse_state_t                            state_o,
  output logic [COUNT_WIDTH-1:0]                           lines_o,
  output esd_pkg::result_t [esd_pkg::MAX_RESULTS-1:0]      res_o,
  output logic [esd_pkg::RCNT_W-1:0]                       cnt_o
);
  import esd_pkg::*;

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
           ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) ||
           ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
    end else if (c <= CHAR_UPPER_F) begin
      v = c - CHAR_UPPER_A + 8'd10;
    end else begin
      v = c - CHAR_LOWER_A + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] letter_code(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61:   r = 8'd7;   // a
      8'h62:   r = 8'd8;   // b
      8'h74:   r = 8'd9;   // t
      8'h6e:   r = 8'd10;  // n
      8'h76:   r = 8'd11;  // v
      8'h66:   r = 8'd12;  // f
      8'h72:   r = 8'd13;  // r
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic result_t byte_word(input logic [7:0] b);
    result_t w;
    w            = '0;
    w.out_byte   = b;
    w.byte_valid = 1'b1;
    return w;
  endfunction

  logic [COUNT_WIDTH+LINE_W-1:0] lines_ext;
  logic [LINE_W-1:0]             lines_sat;
  logic [11:0]                   hex_acc;
  logic [10:0]                   oct_acc;
  logic                          do_plain;
  logic                          newline_hit;
  logic [RIDX_W-1:0]             last_idx;
  parse_state_t                  st;
  logic [RCNT_W-1:0]             cnt;
  result_t [MAX_RESULTS-1:0]     res;
  logic [COUNT_WIDTH-1:0]        lines_inc;

  // Candidate digit accumulations for both radices.
  assign hex_acc = {state_i.digit, 4'b0000} + {8'd0, hex_val(byte_i)};
  assign oct_acc = {state_i.digit, 3'b000} + {8'd0, byte_i[2:0]};

  // Saturating newline increment; at most one newline per byte.
  assign lines_inc = (&lines_i) ? lines_i : lines_i + 1'b1;

  // Main decode: escape handling, digit runs, end of text.
  always_comb begin
    st          = state_i;
    cnt         = '0;
    res         = '0;
    do_plain    = 1'b0;
    newline_hit = 1'b0;
    lines_ext   = '0;
    lines_sat   = '0;
    last_idx    = '0;
    lines_o     = lines_i;

    if (state_i.err == ST_OK) begin
      case (state_i.mode)
        MODE_ESC: begin
          if (byte_i == CHAR_HEX_INTRO) begin
            st.mode = MODE_HEX_FIRST;
          end else if (is_oct(byte_i)) begin
            st.mode  = MODE_OCT;
            st.digit = {5'd0, byte_i[2:0]};
            st.ovf   = 1'b0;
          end else begin
            st.mode = MODE_NORMAL;
            if (byte_i == CHAR_NEWLINE) begin
              newline_hit = 1'b1;
            end
            res[cnt[RIDX_W-1:0]] = byte_word(letter_code(byte_i));
            cnt = cnt + 1'b1;
          end
        end
        MODE_HEX_FIRST: begin
          if (is_hex(byte_i)) begin
            st.mode  = MODE_HEX;
            st.digit = {4'd0, hex_val(byte_i)};
            st.ovf   = 1'b0;
          end else begin
            st.mode = MODE_NORMAL;
            st.err  = ST_BAD_HEX;
          end
        end
        MODE_HEX: begin
          if (is_hex(byte_i)) begin
            st.digit = hex_acc[7:0];
            st.ovf   = state_i.ovf | (|hex_acc[11:8]);
          end else begin
            st.mode = MODE_NORMAL;
            if (state_i.ovf) begin
              st.err = ST_HEX_RANGE;
            end else begin
              res[cnt[RIDX_W-1:0]] = byte_word(state_i.digit);
              cnt = cnt + 1'b1;
              do_plain = 1'b1;
            end
          end
        end
        MODE_OCT: begin
          if (is_oct(byte_i)) begin
            st.digit = oct_acc[7:0];
            st.ovf   = state_i.ovf | (|oct_acc[10:8]);
          end else begin
            st.mode = MODE_NORMAL;
            if (state_i.ovf) begin
              st.err = ST_OCT_RANGE;
            end else begin
              res[cnt[RIDX_W-1:0]] = byte_word(state_i.digit);
              cnt = cnt + 1'b1;
              do_plain = 1'b1;
            end
          end
        end
        default: begin
          st.mode  = MODE_NORMAL;
          do_plain = 1'b1;
        end
      endcase

      // Ordinary text byte, also the byte that ends a digit run.
      if (do_plain) begin
        if (byte_i == CHAR_BACKSLASH) begin
          st.mode = MODE_ESC;
        end else begin
          if (byte_i == CHAR_NEWLINE) begin
            newline_hit = 1'b1;
          end
          res[cnt[RIDX_W-1:0]] = byte_word(byte_i);
          cnt = cnt + 1'b1;
        end
      end
    end

    if (newline_hit) begin
      lines_o = lines_inc;
    end

    // End of text: close any open escape, then give the final status.
    if (last_i) begin
      if (st.err == ST_OK) begin
        case (st.mode)
          MODE_ESC:       st.err = ST_TRAIL;
          MODE_HEX_FIRST: st.err = ST_BAD_HEX;
          MODE_HEX: begin
            if (st.ovf) begin
              st.err = ST_HEX_RANGE;
            end else begin
              res[cnt[RIDX_W-1:0]] = byte_word(st.digit);
              cnt = cnt + 1'b1;
            end
          end
          MODE_OCT: begin
            if (st.ovf) begin
              st.err = ST_OCT_RANGE;
            end else begin
              res[cnt[RIDX_W-1:0]] = byte_word(st.digit);
              cnt = cnt + 1'b1;
            end
          end
          default: ;
        endcase
      end
      lines_ext = {{LINE_W{1'b0}}, lines_o};
      lines_sat = (|lines_ext[COUNT_WIDTH+LINE_W-1:LINE_W]) ? {LINE_W{1'b1}}
                                                           : lines_ext[LINE_W-1:0];
      res[cnt[RIDX_W-1:0]]            = '0;
      res[cnt[RIDX_W-1:0]].done_res   = 1'b1;
      res[cnt[RIDX_W-1:0]].status     = st.err;
      res[cnt[RIDX_W-1:0]].line_count = lines_sat;
      cnt = cnt + 1'b1;
      // The next text starts from a clean state.
      st      = PARSE_RESET;
      lines_o = '0;
    end

    // Flag the last word caused by this byte.
    if (cnt != '0) begin
      last_idx = RIDX_W'(cnt - 1'b1);
      res[last_idx].end_of_run = 1'b1;
    end
  end

  assign state_o = st;
  assign res_o   = res;
  assign cnt_o   = cnt;

endmodule

// ===== hw/rtl/esd_resq.sv =====
// Small result queue: takes up to three words per cycle, gives one per cycle.
module esd_resq (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        push_i,
  input  logic [esd_pkg::RCNT_W-1:0]                  push_cnt_i,
  input  esd_pkg::result_t [esd_pkg::MAX_RESULTS-1:0] push_data_i,
  input  logic                                        pop_i,
  output logic [esd_pkg::QCNT_W-1:0]                  free_o,
  output logic                                        nonempty_o,
  output esd_pkg::result_t                            head_o
);
  import esd_pkg::*;

  result_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d;
  logic [QPTR_W-1:0]   rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic [QCNT_W-1:0]   push_n;
  logic                do_pop;

  assign push_n = push_i ? QCNT_W'(push_cnt_i) : '0;
  assign do_pop = pop_i && (cnt_q != '0);

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_d  = wr_q + QPTR_W'(push_n);
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + push_n - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage: the words of one byte land in consecutive entries.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (RCNT_W'(i) < push_cnt_i) begin
          mem_q[wr_q + QPTR_W'(i)] <= push_data_i[i];
        end
      end
    end
  end

  assign free_o     = QCNT_W'(QUEUE_DEPTH) - cnt_q;
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

endmodule

// ===== hw/rtl/escape_sequence_decoder_core.sv =====
// Top level of the escape sequence decoder: input register, decode, result queue.
//
//   Channel  Direction  Word
//   in_i     sink       in_byte (8), last (1)
//   out_o    source     out_byte (8), byte_valid, end_of_run, done_res, status (3),
//                       line_count (32)
//
// A byte is taken every cycle into the input register and decoded in the next cycle.
// A byte gives zero to three result words; the output channel moves one word a cycle while ready,
// so bytes that close a digit run or end the text take one output transfer per word.
// The input register holds its byte while the four-entry result queue lacks room
// for all of that byte's words, and then the input channel stalls.
// Reset leaves the parser in normal text mode with a zero line count and empty queue.
module escape_sequence_decoder_core #(
  parameter int unsigned COUNT_WIDTH = esd_pkg::COUNT_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  esd_in_if.sink    in_i,
  esd_out_if.source out_o
);
  import esd_pkg::*;

  logic                      stg_valid_q;
  logic [7:0]                stg_byte_q;
  logic                      stg_last_q;
  parse_state_t              pst_q, pst_d;
  logic [COUNT_WIDTH-1:0]    lines_q, lines_d;
  result_t [MAX_RESULTS-1:0] step_res;
  logic [RCNT_W-1:0]         step_cnt;
  logic [QCNT_W-1:0]         q_free;
  logic                      q_nonempty;
  result_t                   q_head;
  logic                      proceed;
  logic                      in_ready;

  // Decode of the registered byte.
  esd_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .state_i (pst_q),
    .lines_i (lines_q),
    .byte_i  (stg_byte_q),
    .last_i  (stg_last_q),
    .state_o (pst_d),
    .lines_o (lines_d),
    .res_o   (step_res),
    .cnt_o   (step_cnt)
  );

  // The byte moves on once the queue has room for all of its words.
  assign proceed  = stg_valid_q && (QCNT_W'(step_cnt) <= q_free);
  assign in_ready = !stg_valid_q || proceed;
  assign in_i.ready = in_ready;

  // Input register and parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      pst_q       <= PARSE_RESET;
      lines_q     <= '0;
    end else begin
      if (in_ready) begin
        stg_valid_q <= in_i.valid;
      end
      if (proceed) begin
        pst_q   <= pst_d;
        lines_q <= lines_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      stg_byte_q <= in_i.in_byte;
      stg_last_q <= in_i.last;
    end
  end

  // Result queue in front of the output channel.
  esd_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (proceed),
    .push_cnt_i  (step_cnt),
    .push_data_i (step_res),
    .pop_i       (out_o.ready),
    .free_o      (q_free),
    .nonempty_o  (q_nonempty),
    .head_o      (q_head)
  );

  assign out_o.valid      = q_nonempty;
  assign out_o.out_byte   = q_head.out_byte;
  assign out_o.byte_valid = q_head.byte_valid;
  assign out_o.end_of_run = q_head.end_of_run;
  assign out_o.done_res   = q_head.done_res;
  assign out_o.status     = q_head.status;
  assign out_o.line_count = q_head.line_count;

  // After an error only the last byte of the text yields a word.
  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && (pst_q.err != ST_OK) && !stg_last_q) |-> (step_cnt == '0))
    else $error("word produced after an error");

  // The last byte always gives the final status and returns the parser to reset.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && stg_last_q) |=> ((pst_q == PARSE_RESET) && (lines_q == '0)))
    else $error("parser state not cleared after the last byte");

  a_last_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && stg_last_q) |-> (step_cnt != '0))
    else $error("last byte gave no final status");

  // A held byte blocks the input channel.
  a_hold_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid_q && !proceed) |=> (stg_valid_q && $stable(stg_byte_q)))
    else $error("held byte lost");

  // A word is never both a decoded byte and a final status.
  a_word_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.byte_valid && out_o.done_res))
    else $error("word marked as byte and status at once");

endmodule

// ===== sim/esd_decode_checker.sv =====
// Checker of the escape sequence decoder: predicts the output words from accepted input words.
module esd_decode_checker #(
  parameter int unsigned COUNT_WIDTH = esd_pkg::COUNT_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  esd_in_if    in_i,
  esd_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);
  import esd_pkg::*;

  // Predicted parser state.
  mode_e                  pmode;
  logic [7:0]             acc_digit;
  logic                   acc_ovf;
  status_e                err_code;
  logic [COUNT_WIDTH-1:0] nl_total;

  // Words caused by the byte being decoded, and all words still awaited.
  result_t step_words [MAX_RESULTS];
  int      step_n;
  result_t expected_words [$];

  int mismatches;
  int words_seen;

  // Back to the state of a fresh text.
  function automatic void clear_parser();
    pmode     = MODE_NORMAL;
    acc_digit = 8'd0;
    acc_ovf   = 1'b0;
    err_code  = ST_OK;
    nl_total  = '0;
  endfunction

  function automatic void emit_word(logic [7:0] b, logic is_byte, logic is_done, status_e st,
                                    logic [LINE_W-1:0] lc);
    result_t w;
    w.out_byte   = b;
    w.byte_valid = is_byte;
    w.end_of_run = 1'b0;
    w.done_res   = is_done;
    w.status     = st;
    w.line_count = lc;
    step_words[step_n] = w;
    step_n++;
  endfunction

  // The newline count sticks at its maximum.
  function automatic void count_line();
    if (nl_total != '1) begin
      nl_total = nl_total + 1'b1;
    end
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_SEVEN;
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return (c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) ||
           (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F);
  endfunction

  function automatic logic [3:0] hex_value(logic [7:0] c);
    if (c <= CHAR_NINE) begin
      return 4'(c - CHAR_ZERO);
    end
    if (c <= CHAR_UPPER_F) begin
      return 4'(c - CHAR_UPPER_A + 8'd10);
    end
    return 4'(c - CHAR_LOWER_A + 8'd10);
  endfunction

  // Control code of a single-letter escape; other letters stand for themselves.
  function automatic logic [7:0] escape_code(logic [7:0] c);
    case (c)
      "a": return 8'd7;
      "b": return 8'd8;
      "t": return 8'd9;
      "n": return 8'd10;
      "v": return 8'd11;
      "f": return 8'd12;
      "r": return 8'd13;
      default: return c;
    endcase
  endfunction

  // A value that ever passes 255 marks the run as out of range.
  function automatic void add_digit(logic [3:0] d, int unsigned radix);
    int unsigned v;
    v = acc_digit * radix + d;
    if (v > 255) begin
      acc_ovf = 1'b1;
    end
    acc_digit = 8'(v);
  endfunction

  // Ends a digit run; false when the run was out of range.
  function automatic logic close_run(status_e range_err);
    pmode = MODE_NORMAL;
    if (acc_ovf) begin
      err_code = range_err;
      return 1'b0;
    end
    emit_word(acc_digit, 1'b1, 1'b0, ST_OK, '0);
    return 1'b1;
  endfunction

  function automatic void plain_byte(logic [7:0] c);
    if (c == CHAR_BACKSLASH) begin
      pmode = MODE_ESC;
    end else begin
      if (c == CHAR_NEWLINE) begin
        count_line();
      end
      emit_word(c, 1'b1, 1'b0, ST_OK, '0);
    end
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    case (pmode)
      MODE_ESC: begin
        if (c == CHAR_HEX_INTRO) begin
          pmode = MODE_HEX_FIRST;
        end else if (is_octal(c)) begin
          pmode     = MODE_OCT;
          acc_digit = c - CHAR_ZERO;
          acc_ovf   = 1'b0;
        end else begin
          pmode = MODE_NORMAL;
          if (c == CHAR_NEWLINE) begin
            count_line();
          end
          emit_word(escape_code(c), 1'b1, 1'b0, ST_OK, '0);
        end
      end
      MODE_HEX_FIRST: begin
        if (is_hex(c)) begin
          pmode     = MODE_HEX;
          acc_digit = 8'(hex_value(c));
          acc_ovf   = 1'b0;
        end else begin
          pmode    = MODE_NORMAL;
          err_code = ST_BAD_HEX;
        end
      end
      MODE_HEX: begin
        if (is_hex(c)) begin
          add_digit(hex_value(c), 16);
        end else if (close_run(ST_HEX_RANGE)) begin
          plain_byte(c);
        end
      end
      MODE_OCT: begin
        if (is_octal(c)) begin
          add_digit(4'(c - CHAR_ZERO), 8);
        end else if (close_run(ST_OCT_RANGE)) begin
          plain_byte(c);
        end
      end
      default: begin
        pmode = MODE_NORMAL;
        plain_byte(c);
      end
    endcase
  endfunction

  // Final status word: an open escape or run is settled first.
  function automatic void close_text();
    logic [LINE_W-1:0] lc;
    if (err_code == ST_OK) begin
      case (pmode)
        MODE_ESC:       err_code = ST_TRAIL;
        MODE_HEX_FIRST: err_code = ST_BAD_HEX;
        MODE_HEX:       void'(close_run(ST_HEX_RANGE));
        MODE_OCT:       void'(close_run(ST_OCT_RANGE));
        default:        ;
      endcase
    end
    if (COUNT_WIDTH > LINE_W && (nl_total >> LINE_W) != 0) begin
      lc = '1;
    end else begin
      lc = LINE_W'(nl_total);
    end
    emit_word(8'd0, 1'b0, 1'b1, err_code, lc);
  endfunction

  // Works out the words one input word causes and queues them.
  function automatic void decode_text_byte(logic [7:0] c, logic is_last);
    step_n = 0;
    if (err_code == ST_OK) begin
      parse_byte(c);
    end
    if (is_last) begin
      close_text();
      clear_parser();
    end
    if (step_n > 0) begin
      step_words[step_n-1].end_of_run = 1'b1;
    end
    for (int k = 0; k < step_n; k++) begin
      expected_words.push_back(step_words[k]);
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 100) begin
      $display("output word %0d: %s is %0h, expected %0h", words_seen, field, got, want);
    end
    mismatches++;
  endtask

  // Compares one output word with the oldest expectation, field by field.
  task automatic check_word();
    result_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("word with none awaited, out_byte", 32'(out_i.out_byte), 32'd0);
    end else begin
      want = expected_words.pop_front();
      if (out_i.out_byte !== want.out_byte) begin
        report_mismatch("out_byte", 32'(out_i.out_byte), 32'(want.out_byte));
      end
      if (out_i.byte_valid !== want.byte_valid) begin
        report_mismatch("byte_valid", 32'(out_i.byte_valid), 32'(want.byte_valid));
      end
      if (out_i.end_of_run !== want.end_of_run) begin
        report_mismatch("end_of_run", 32'(out_i.end_of_run), 32'(want.end_of_run));
      end
      if (out_i.done_res !== want.done_res) begin
        report_mismatch("done_res", 32'(out_i.done_res), 32'(want.done_res));
      end
      if (out_i.status !== want.status) begin
        report_mismatch("status", 32'(out_i.status), 32'(want.status));
      end
      if (out_i.line_count !== want.line_count) begin
        report_mismatch("line_count", out_i.line_count, want.line_count);
      end
    end
    words_seen++;
  endtask

  // Watch both channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_words.delete();
      mismatches   = 0;
      words_seen   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        decode_text_byte(in_i.in_byte, in_i.last);
      end
      if (out_i.valid && out_i.ready) begin
        check_word();
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_words.size();
    end
  end

endmodule

// ===== sim/escape_sequence_decoder_core_test.sv =====
// Testbench top of the escape sequence decoder: clock, reset, text stimulus and verdict.
module escape_sequence_decoder_core_test;
  import esd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TEXT_BYTES  = 470;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   sent_count;

  logic [7:0] text_q [$];

  esd_in_if  in_ch ();
  esd_out_if out_ch ();

  escape_sequence_decoder_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  esd_decode_checker decode_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sends the bytes of text_q, marking the final one; starts and ends at a falling edge.
  task automatic send_text();
    int idle_pct;
    for (int k = 0; k < text_q.size(); k++) begin
      idle_pct = (sent_count < 160) ? 14 : (sent_count < 320) ? 58 : 0;
      while ($urandom_range(99) < idle_pct) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
      in_ch.valid   <= 1'b1;
      in_ch.in_byte <= text_q[k];
      in_ch.last    <= (k == text_q.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
      sent_count++;
      @(negedge clk);
    end
  endtask

  // Receiver: random stalls by phase, and two long hold-offs that fill the block.
  initial begin
    int hold_left;
    int next_hold;
    int recv_pct;
    out_ch.ready = 1'b0;
    hold_left    = 0;
    next_hold    = 60;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left == 0 && sent_count >= next_hold) begin
        hold_left = 300;
        next_hold = (next_hold == 60) ? 420 : 32'h7fff_ffff;
      end
      recv_pct = (sent_count < 160) ? 58 : (sent_count < 320) ? 14 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int pieces;
    int pick;
    int n;
    int d;
    logic [7:0] ch;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'd0;
    in_ch.last    = 1'b0;
    sent_count    = 0;
    rst_n         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extreme bytes, a raw newline, a hex run closed by a trailing backslash.
    text_q = {8'h00, 8'hff, CHAR_NEWLINE, CHAR_BACKSLASH, CHAR_HEX_INTRO, CHAR_LOWER_A,
              CHAR_SEVEN, CHAR_BACKSLASH};
    send_text();
    // Octal run closed by a newline on the last byte: three words at once.
    text_q = {CHAR_BACKSLASH, 8'h31, CHAR_SEVEN, CHAR_NEWLINE};
    send_text();
    // Text ending right after the hex introducer.
    text_q = {CHAR_BACKSLASH, CHAR_HEX_INTRO};
    send_text();
    // Hex introducer without a digit; the byte after the error is dropped.
    text_q = {CHAR_BACKSLASH, CHAR_HEX_INTRO, 8'h67, CHAR_UPPER_A};
    send_text();
    // Hex value out of range at the end of the text.
    text_q = {CHAR_BACKSLASH, CHAR_HEX_INTRO, CHAR_UPPER_F, CHAR_UPPER_F, CHAR_UPPER_F};
    send_text();
    // Octal value out of range at the end of the text.
    text_q = {CHAR_BACKSLASH, 8'h34, CHAR_ZERO, CHAR_ZERO};
    send_text();
    // Escaped newline, then an escaped ordinary letter.
    text_q = {CHAR_BACKSLASH, CHAR_NEWLINE, CHAR_BACKSLASH, 8'h71};
    send_text();

    // Random texts built mostly from well-formed pieces.
    while (sent_count < TEXT_BYTES) begin
      pieces = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      text_q.delete();
      repeat (pieces) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          // Printable character; a backslash becomes an underscore.
          ch = 8'($urandom_range(32, 126));
          text_q.push_back((ch == CHAR_BACKSLASH) ? 8'h5f : ch);
        end else if (pick < 38) begin
          text_q.push_back(CHAR_NEWLINE);
        end else if (pick < 42) begin
          text_q.push_back(8'($urandom_range(255)));
        end else if (pick < 57) begin
          case ($urandom_range(7))
            0: ch = "0";
            1: ch = "a";
            2: ch = "b";
            3: ch = "t";
            4: ch = "n";
            5: ch = "v";
            6: ch = "f";
            default: ch = "r";
          endcase
          text_q.push_back(CHAR_BACKSLASH);
          text_q.push_back(ch);
        end else if (pick < 61) begin
          text_q.push_back(CHAR_BACKSLASH);
          text_q.push_back(8'($urandom_range(255)));
        end else if (pick < 63) begin
          text_q.push_back(CHAR_BACKSLASH);
          text_q.push_back(CHAR_NEWLINE);
        end else if (pick < 79) begin
          // Hex escape in mixed case; three digits usually overflow.
          text_q.push_back(CHAR_BACKSLASH);
          text_q.push_back(CHAR_HEX_INTRO);
          n = ($urandom_range(7) == 0) ? 3 : $urandom_range(1, 2);
          repeat (n) begin
            d = $urandom_range(15);
            if (d < 10) begin
              ch = 8'(CHAR_ZERO + d);
            end else begin
              ch = 8'(($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + d - 10);
            end
            text_q.push_back(ch);
          end
        end else if (pick < 95) begin
          // Octal escape; four digits nearly always overflow.
          text_q.push_back(CHAR_BACKSLASH);
          n = ($urandom_range(9) == 0) ? 4 : $urandom_range(1, 3);
          repeat (n) begin
            text_q.push_back(8'(CHAR_ZERO + $urandom_range(7)));
          end
        end else if (pick < 97) begin
          // Hex introducer followed by a letter that is no hex digit.
          text_q.push_back(CHAR_BACKSLASH);
          text_q.push_back(CHAR_HEX_INTRO);
          text_q.push_back(8'(8'h67 + $urandom_range(19)));
        end else begin
          text_q.push_back(CHAR_BACKSLASH);
        end
      end
      send_text();
    end
    in_ch.valid <= 1'b0;

    // Drain the outstanding words, then allow the pipeline to settle.
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/esd_pkg.sv
hw/rtl/esd_in_if.sv
hw/rtl/esd_out_if.sv
hw/rtl/esd_step.sv
hw/rtl/esd_resq.sv
hw/rtl/escape_sequence_decoder_core.sv
sim/esd_decode_checker.sv
sim/escape_sequence_decoder_core_test.sv
